// ----- hdl/cbfm_pkg.sv -----
// Package for the clock buffer frame manager: sizes, mode and status codes,
// and the command and status structs between controller and datapath. No dependencies.
package cbfm_pkg;
   localparam int FRAMES_DEF       = 16;
   localparam int FILE_ID_BITS_DEF = 8;
   localparam int PAGE_NO_BITS_DEF = 20;
   localparam int PIN_BITS_DEF     = 8;
   localparam int MODE_W   = 3;
   localparam int STATUS_W = 3;
   localparam int FRAME_W  = 4;
   localparam int FILE_W   = 8;
   localparam int PAGE_W   = 20;
   localparam int SWEEP_ROUNDS = 2;

   localparam logic [MODE_W-1:0] MODE_READ     = 3'd0;
   localparam logic [MODE_W-1:0] MODE_UNPIN    = 3'd1;
   localparam logic [MODE_W-1:0] MODE_ALLOC    = 3'd2;
   localparam logic [MODE_W-1:0] MODE_DISPOSE  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_FLUSH    = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_EXCEEDED  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NOT_PIN   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_PINNED    = 3'd4;
   localparam logic [STATUS_W-1:0] ST_RESIDENT  = 3'd5;
   localparam logic [STATUS_W-1:0] ST_PIN_LIMIT = 3'd6;

   // Datapath operation codes
   typedef enum logic [3:0] {
      OP_NONE, OP_LATCH, OP_LOOKUP, OP_PIN, OP_UNPIN, OP_DISPOSE,
      OP_HAND_STEP, OP_REF_CLEAR, OP_TAKE, OP_INSTALL, OP_FLUSH_INV, OP_SCAN_STEP,
      OP_SCAN_START
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   // Status seen by the controller on the current frame
   typedef struct packed {
      logic       hit;
      logic       hit_pins_zero;
      logic       hit_pins_max;
      logic [2:0] mode;
      logic       mark_dirty;
      logic       cur_valid;
      logic       cur_ref;
      logic       cur_dirty;
      logic       cur_pins_zero;
      logic       cur_file_match;
      logic       hand_at_start;
      logic       scan_last;
   } stat_type;
endpackage

// ----- hdl/clock_buffer_frame_manager_top.sv -----
// Clock buffer frame manager top level: one request at a time.
// Hits, unpin, dispose and unused modes pass through the lookup and decide states
// before the result is offered; a miss first sweeps the frames with the clock hand;
// flush first scans the frames and sends a result transfer per write-back.
// A new request is taken after the last transfer.
// Reset clears the valid, reference, dirty and pin state of all frames and sets the clock hand to FRAMES-1.
module clock_buffer_frame_manager_top import cbfm_pkg::*; #(
   parameter int FRAMES       = FRAMES_DEF,
   parameter int FILE_ID_BITS = FILE_ID_BITS_DEF,
   parameter int PAGE_NO_BITS = PAGE_NO_BITS_DEF,
   parameter int PIN_BITS     = PIN_BITS_DEF,
   localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [MODE_W-1:0]       req_mode,
   input  logic [FILE_ID_BITS-1:0] req_file_id,
   input  logic [PAGE_NO_BITS-1:0] req_page_no,
   input  logic                    req_mark_dirty,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [STATUS_W-1:0]     rsp_status,
   output logic [IDX_W-1:0]        rsp_frame,
   output logic                    rsp_fetch_needed,
   output logic                    rsp_writeback_valid,
   output logic [FILE_ID_BITS-1:0] rsp_writeback_file,
   output logic [PAGE_NO_BITS-1:0] rsp_writeback_page,
   output logic                    rsp_last
);
   cmd_type                 cmd;
   stat_type                stat;
   logic [IDX_W-1:0]        hit_idx, cur_idx;
   logic [FILE_ID_BITS-1:0] cur_file;
   logic [PAGE_NO_BITS-1:0] cur_page;

   cbfm_datapath #(.FRAMES(FRAMES), .FILE_ID_BITS(FILE_ID_BITS),
      .PAGE_NO_BITS(PAGE_NO_BITS), .PIN_BITS(PIN_BITS)) u_dp (
      .clock, .reset, .cmd, .req_mode, .req_file_id, .req_page_no,
      .req_mark_dirty, .stat, .hit_idx, .cur_idx, .cur_file, .cur_page);

   cbfm_ctrl #(.FRAMES(FRAMES), .FILE_ID_BITS(FILE_ID_BITS),
      .PAGE_NO_BITS(PAGE_NO_BITS)) u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready, .stat,
      .hit_idx, .cur_idx, .cur_file, .cur_page, .cmd, .rsp_status, .rsp_frame,
      .rsp_fetch_needed, .rsp_writeback_valid, .rsp_writeback_file,
      .rsp_writeback_page, .rsp_last);
endmodule

// ----- hdl/cbfm_datapath.sv -----
// Datapath: frame descriptor registers, request latch, clock hand, flush
// scan index and associative tag match. Depends on cbfm_pkg.
module cbfm_datapath import cbfm_pkg::*; #(
   parameter int FRAMES       = FRAMES_DEF,
   parameter int FILE_ID_BITS = FILE_ID_BITS_DEF,
   parameter int PAGE_NO_BITS = PAGE_NO_BITS_DEF,
   parameter int PIN_BITS     = PIN_BITS_DEF,
   localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  cmd_type                  cmd,
   input  logic [MODE_W-1:0]        req_mode,
   input  logic [FILE_ID_BITS-1:0]  req_file_id,
   input  logic [PAGE_NO_BITS-1:0]  req_page_no,
   input  logic                     req_mark_dirty,
   output stat_type                 stat,
   output logic [IDX_W-1:0]         hit_idx,
   output logic [IDX_W-1:0]         cur_idx,
   output logic [FILE_ID_BITS-1:0]  cur_file,
   output logic [PAGE_NO_BITS-1:0]  cur_page
);
   logic [FRAMES-1:0]       valid_ff, ref_ff, dirty_ff;
   logic [PIN_BITS-1:0]     pins_ff [FRAMES];
   logic [FILE_ID_BITS-1:0] ftag_ff [FRAMES];
   logic [PAGE_NO_BITS-1:0] ptag_ff [FRAMES];
   logic [IDX_W-1:0]        hand_ff, start_ff, scan_ff, hit_ff;
   logic                    hitv_ff;
   logic [MODE_W-1:0]       mode_ff;
   logic [FILE_ID_BITS-1:0] file_ff;
   logic [PAGE_NO_BITS-1:0] page_ff;
   logic                    md_ff;
   logic [IDX_W-1:0]        hand_in, cur;
   logic [FRAMES-1:0]       match;
   logic [IDX_W-1:0]        match_idx;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAMES - 1);
   localparam logic [PIN_BITS-1:0] PIN_MAX = {PIN_BITS{1'b1}};

   assign hand_in = (hand_ff == LAST_IDX) ? '0 : hand_ff + 1'b1;
   assign cur = (cmd.op == OP_FLUSH_INV || cmd.op == OP_SCAN_STEP) ? scan_ff :
                (mode_ff == MODE_FLUSH) ? scan_ff : hand_ff;

   // match latched tags against all valid frames, lowest index wins
   always_comb begin
      match_idx = '0;
      for (int i = FRAMES - 1; i >= 0; i--) begin
         match[i] = valid_ff[i] && ftag_ff[i] == file_ff && ptag_ff[i] == page_ff;
         if (match[i]) match_idx = IDX_W'(i);
      end
   end

   always_comb begin
      stat.hit            = hitv_ff;
      stat.hit_pins_zero  = pins_ff[hit_ff] == '0;
      stat.hit_pins_max   = pins_ff[hit_ff] == PIN_MAX;
      stat.mode           = mode_ff;
      stat.mark_dirty     = md_ff;
      stat.cur_valid      = valid_ff[cur];
      stat.cur_ref        = ref_ff[cur];
      stat.cur_dirty      = dirty_ff[cur];
      stat.cur_pins_zero  = pins_ff[cur] == '0;
      stat.cur_file_match = ftag_ff[cur] == file_ff;
      stat.hand_at_start  = hand_in == start_ff;
      stat.scan_last      = scan_ff == LAST_IDX;
   end
   assign hit_idx  = hit_ff;
   assign cur_idx  = cur;
   assign cur_file = ftag_ff[cur];
   assign cur_page = ptag_ff[cur];

   // update descriptors as commanded
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         ref_ff   <= '0;
         dirty_ff <= '0;
         for (int i = 0; i < FRAMES; i++) pins_ff[i] <= '0;
         hand_ff  <= LAST_IDX;
         hitv_ff  <= 1'b0;
      end else begin
         case (cmd.op)
            OP_LATCH: begin
               mode_ff <= req_mode;
               file_ff <= req_file_id;
               page_ff <= req_page_no;
               md_ff   <= req_mark_dirty;
            end
            OP_LOOKUP: begin
               hitv_ff  <= |match;
               hit_ff   <= match_idx;
               start_ff <= hand_ff;
            end
            OP_PIN: begin
               ref_ff[hit_ff]  <= 1'b1;
               pins_ff[hit_ff] <= pins_ff[hit_ff] + 1'b1;
            end
            OP_UNPIN: begin
               pins_ff[hit_ff] <= pins_ff[hit_ff] - 1'b1;
               if (md_ff) dirty_ff[hit_ff] <= 1'b1;
            end
            OP_DISPOSE: begin
               valid_ff[hit_ff] <= 1'b0;
               ref_ff[hit_ff]   <= 1'b0;
               dirty_ff[hit_ff] <= 1'b0;
               pins_ff[hit_ff]  <= '0;
            end
            OP_HAND_STEP: hand_ff <= hand_in;
            // clear the reference bit and move the hand on
            OP_REF_CLEAR: begin
               ref_ff[cur] <= 1'b0;
               hand_ff     <= hand_in;
            end
            OP_INSTALL: begin
               valid_ff[cur] <= 1'b1;
               ref_ff[cur]   <= 1'b1;
               dirty_ff[cur] <= 1'b0;
               pins_ff[cur]  <= PIN_BITS'(1);
               ftag_ff[cur]  <= file_ff;
               ptag_ff[cur]  <= page_ff;
            end
            OP_FLUSH_INV: begin
               valid_ff[cur] <= 1'b0;
               dirty_ff[cur] <= 1'b0;
               if (scan_ff != LAST_IDX) scan_ff <= scan_ff + 1'b1;
            end
            OP_SCAN_STEP: if (scan_ff != LAST_IDX) scan_ff <= scan_ff + 1'b1;
            OP_SCAN_START: scan_ff <= '0;
            default: ;
         endcase
      end
   end
endmodule

// ----- hdl/cbfm_ctrl.sv -----
// Controller: sequences lookup, clock sweep and flush scan, and holds the
// result register. Depends on cbfm_pkg.
module cbfm_ctrl import cbfm_pkg::*; #(
   parameter int FRAMES       = FRAMES_DEF,
   parameter int FILE_ID_BITS = FILE_ID_BITS_DEF,
   parameter int PAGE_NO_BITS = PAGE_NO_BITS_DEF,
   localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  stat_type                stat,
   input  logic [IDX_W-1:0]        hit_idx,
   input  logic [IDX_W-1:0]        cur_idx,
   input  logic [FILE_ID_BITS-1:0] cur_file,
   input  logic [PAGE_NO_BITS-1:0] cur_page,
   output cmd_type                 cmd,
   output logic [STATUS_W-1:0]     rsp_status,
   output logic [IDX_W-1:0]        rsp_frame,
   output logic                    rsp_fetch_needed,
   output logic                    rsp_writeback_valid,
   output logic [FILE_ID_BITS-1:0] rsp_writeback_file,
   output logic [PAGE_NO_BITS-1:0] rsp_writeback_page,
   output logic                    rsp_last
);
   typedef enum logic [2:0] {S_IDLE, S_LOOK, S_DECIDE, S_SWEEP, S_SCAN, S_OUT} state_type;
   state_type state_ff;
   logic      rounds_ff, wb_ff;

   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = state_ff == S_OUT;

   // drive datapath command from state and status
   always_comb begin
      cmd.op = OP_NONE;
      case (state_ff)
         S_IDLE:   if (req_valid) cmd.op = OP_LATCH;
         S_LOOK:   cmd.op = OP_LOOKUP;
         S_DECIDE: begin
            case (stat.mode)
               MODE_READ: if (stat.hit && !stat.hit_pins_max) cmd.op = OP_PIN;
               MODE_UNPIN: if (stat.hit && !stat.hit_pins_zero) cmd.op = OP_UNPIN;
               MODE_DISPOSE: if (stat.hit) cmd.op = OP_DISPOSE;
               MODE_FLUSH: cmd.op = OP_SCAN_START;
               default: ;
            endcase
            if ((stat.mode == MODE_READ || stat.mode == MODE_ALLOC) && !stat.hit)
               cmd.op = OP_HAND_STEP;
         end
         S_SWEEP: begin
            if (!stat.cur_valid) cmd.op = OP_INSTALL;
            else if (stat.cur_ref) cmd.op = OP_REF_CLEAR;
            else if (stat.cur_pins_zero) cmd.op = OP_INSTALL;
            else cmd.op = OP_HAND_STEP;
         end
         S_SCAN: begin
            if (stat.cur_valid && stat.cur_file_match && !stat.cur_pins_zero)
               cmd.op = OP_NONE;
            else if (stat.cur_valid && stat.cur_file_match) cmd.op = OP_FLUSH_INV;
            else cmd.op = OP_SCAN_STEP;
         end
         default: ;
      endcase
   end

   // hold state, sweep bookkeeping and the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rounds_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: if (req_valid) state_ff <= S_LOOK;
            S_LOOK: state_ff <= S_DECIDE;
            S_DECIDE: begin
               rsp_status <= ST_OK;
               rsp_frame <= '0;
               rsp_fetch_needed <= 1'b0;
               rsp_writeback_valid <= 1'b0;
               rsp_writeback_file <= '0;
               rsp_writeback_page <= '0;
               rsp_last <= 1'b1;
               rounds_ff <= 1'b0;
               state_ff <= S_OUT;
               case (stat.mode)
                  MODE_READ, MODE_ALLOC: begin
                     if (stat.hit) begin
                        rsp_frame <= hit_idx;
                        if (stat.mode == MODE_ALLOC) rsp_status <= ST_RESIDENT;
                        else if (stat.hit_pins_max) rsp_status <= ST_PIN_LIMIT;
                     end else begin
                        if (stat.hand_at_start) rounds_ff <= 1'b1;
                        state_ff <= S_SWEEP;
                     end
                  end
                  MODE_UNPIN: begin
                     if (!stat.hit) rsp_status <= ST_NOT_FOUND;
                     else begin
                        rsp_frame <= hit_idx;
                        if (stat.hit_pins_zero) rsp_status <= ST_NOT_PIN;
                     end
                  end
                  MODE_DISPOSE: if (stat.hit) rsp_frame <= hit_idx;
                  MODE_FLUSH: state_ff <= S_SCAN;
                  default: ;
               endcase
            end
            S_SWEEP: begin
               if (!stat.cur_valid || (!stat.cur_ref && stat.cur_pins_zero)) begin
                  rsp_status <= ST_OK;
                  rsp_frame <= cur_idx;
                  rsp_fetch_needed <= stat.mode == MODE_READ;
                  rsp_writeback_valid <= stat.cur_valid && stat.cur_dirty;
                  rsp_writeback_file <= (stat.cur_valid && stat.cur_dirty) ?
                                        cur_file : '0;
                  rsp_writeback_page <= (stat.cur_valid && stat.cur_dirty) ?
                                        cur_page : '0;
                  state_ff <= S_OUT;
               end else if (stat.hand_at_start && rounds_ff) begin
                  // second return to start: buffer exceeded, hand rests on start
                  rsp_status <= ST_EXCEEDED;
                  state_ff <= S_OUT;
               end else begin
                  if (stat.hand_at_start) rounds_ff <= 1'b1;
                  state_ff <= S_SWEEP;
               end
            end
            S_SCAN: begin
               if (stat.cur_valid && stat.cur_file_match && !stat.cur_pins_zero) begin
                  rsp_status <= ST_PINNED;
                  rsp_frame <= cur_idx;
                  rsp_writeback_valid <= 1'b0;
                  rsp_writeback_file <= '0;
                  rsp_writeback_page <= '0;
                  rsp_last <= 1'b1;
                  state_ff <= S_OUT;
               end else if (stat.cur_valid && stat.cur_file_match && stat.cur_dirty) begin
                  rsp_status <= ST_OK;
                  rsp_frame <= cur_idx;
                  rsp_writeback_valid <= 1'b1;
                  rsp_writeback_file <= cur_file;
                  rsp_writeback_page <= cur_page;
                  rsp_last <= 1'b0;
                  wb_ff <= stat.scan_last;
                  state_ff <= S_OUT;
               end else if (stat.scan_last) begin
                  rsp_status <= ST_OK;
                  rsp_frame <= '0;
                  rsp_writeback_valid <= 1'b0;
                  rsp_writeback_file <= '0;
                  rsp_writeback_page <= '0;
                  rsp_last <= 1'b1;
                  state_ff <= S_OUT;
               end
            end
            S_OUT: if (rsp_ready) begin
               if (rsp_last) state_ff <= S_IDLE;
               else if (wb_ff) begin
                  // scan ended on a write-back: send the closing transfer
                  rsp_status <= ST_OK;
                  rsp_frame <= '0;
                  rsp_writeback_valid <= 1'b0;
                  rsp_writeback_file <= '0;
                  rsp_writeback_page <= '0;
                  rsp_last <= 1'b1;
               end else state_ff <= S_SCAN;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
